[sv/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the netpbm stream parser: request and response
// payloads, parser phases, result kinds, error codes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

   localparam int DEF_MAX_TOKEN = 64;
   localparam int DEF_MAX_DIM   = 4096;

   localparam int DIM_OUT_W = 13;
   localparam int VAL_W     = 16;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NO_P       = 3'd0;
   localparam logic [2:0] ERR_BAD_DIGIT  = 3'd1;
   localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
   localparam logic [2:0] ERR_WIDTH      = 3'd3;
   localparam logic [2:0] ERR_HEIGHT     = 3'd4;
   localparam logic [2:0] ERR_MAXVAL     = 3'd5;
   localparam logic [2:0] ERR_SHORT_DATA = 3'd6;
   localparam logic [2:0] ERR_LONG_TOKEN = 3'd7;

   // Progress of the magic token.
   localparam logic [1:0] MAGIC_NONE     = 2'd0;
   localparam logic [1:0] MAGIC_P        = 2'd1;
   localparam logic [1:0] MAGIC_OK       = 2'd2;
   localparam logic [1:0] MAGIC_BAD_TYPE = 2'd3;

   // Netpbm file types.
   localparam logic [2:0] PNM_ASCII_GRAY  = 3'd2;
   localparam logic [2:0] PNM_ASCII_RGB   = 3'd3;
   localparam logic [2:0] PNM_BINARY_GRAY = 3'd5;
   localparam logic [2:0] PNM_BINARY_RGB  = 3'd6;

   // Character codes.
   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_WIDTH  = 3'd1,
      PH_HEIGHT = 3'd2,
      PH_MAXVAL = 3'd3,
      PH_DATA   = 3'd4,
      PH_IDLE   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       start_of_file;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           pixel;
      logic [DIM_OUT_W-1:0] image_width;
      logic [DIM_OUT_W-1:0] image_height;
      logic [VAL_W-1:0]     max_value;
      logic                 is_colour;
      logic                 ascii_mode;
      logic                 last;
      logic [2:0]           error_code;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

`default_nettype wire

[sv/nps_stream_if.sv]
// ----------------------------------------------------------------------------
// nps_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[sv/nps_parser.sv]
// ----------------------------------------------------------------------------
// nps_parser
// Parser state and the single-pass update for one file byte. Produces at most
// one result per step; the caller registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_parser #(
   parameter int MAX_TOKEN = nps_pkg::DEF_MAX_TOKEN,
   parameter int MAX_DIM   = nps_pkg::DEF_MAX_DIM
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire nps_pkg::req_type     item,
   output nps_pkg::result_type       result
);

   localparam int LEN_W  = $clog2(MAX_TOKEN + 1);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int AREA_W = 2 * DIM_W;
   localparam int REM_W  = $clog2(3 * MAX_DIM * MAX_DIM + 1);
   localparam int VAL_W  = nps_pkg::VAL_W;

   nps_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         file_type_ff, file_type_in;
   logic [LEN_W-1:0]   tok_len_ff, tok_len_in;
   logic [VAL_W-1:0]   tok_val_ff, tok_val_in;
   logic               digits_ended_ff, digits_ended_in;
   logic [1:0]         magic_ff, magic_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [VAL_W-1:0]   maxval_ff, maxval_in;
   logic [REM_W-1:0]   remaining_ff, remaining_in;
   logic [AREA_W-1:0]  area_ff, area_in;

   // View of the state after an optional restart by start_of_file.
   nps_pkg::phase_type eff_phase;
   logic [2:0]         eff_type;
   logic [LEN_W-1:0]   eff_len;
   logic [VAL_W-1:0]   eff_val;
   logic               eff_ended;
   logic [1:0]         eff_magic;

   logic [7:0]         c;
   logic               eof;
   logic               is_digit;
   logic [3:0]         digit;
   logic               is_sep;
   logic               ascii_type;
   logic               colour_type;
   logic               active;
   logic               binary_data;
   logic               token_end;
   logic               long_token;
   logic               dim_ok;
   logic               val_zero;
   logic [REM_W-1:0]   rem_dec;
   logic [VAL_W+3:0]   val_x10;
   logic               good_type;

   always_comb begin
      c         = item.byte_req;
      eof       = item.end_of_file;
      eff_phase = item.start_of_file ? nps_pkg::PH_MAGIC : phase_ff;
      eff_type  = item.start_of_file ? 3'd0 : file_type_ff;
      eff_len   = item.start_of_file ? '0 : tok_len_ff;
      eff_val   = item.start_of_file ? '0 : tok_val_ff;
      eff_ended = item.start_of_file ? 1'b0 : digits_ended_ff;
      eff_magic = item.start_of_file ? nps_pkg::MAGIC_NONE : magic_ff;

      is_digit    = (c >= nps_pkg::CH_ZERO) && (c <= nps_pkg::CH_NINE);
      digit       = 4'(c - nps_pkg::CH_ZERO);
      is_sep      = (c == nps_pkg::CH_SPACE) || (c == nps_pkg::CH_NEWLINE);
      ascii_type  = (eff_type == nps_pkg::PNM_ASCII_GRAY) ||
                    (eff_type == nps_pkg::PNM_ASCII_RGB);
      colour_type = (eff_type == nps_pkg::PNM_ASCII_RGB) ||
                    (eff_type == nps_pkg::PNM_BINARY_RGB);
      good_type   = (3'(digit) == nps_pkg::PNM_ASCII_GRAY) ||
                    (3'(digit) == nps_pkg::PNM_ASCII_RGB) ||
                    (3'(digit) == nps_pkg::PNM_BINARY_GRAY) ||
                    (3'(digit) == nps_pkg::PNM_BINARY_RGB);

      active      = (eff_phase != nps_pkg::PH_IDLE);
      binary_data = (eff_phase == nps_pkg::PH_DATA) && !ascii_type;
      token_end   = active && !binary_data && (eof || is_sep);
      long_token  = (eff_len == LEN_W'(MAX_TOKEN));

      val_zero = (eff_val == '0);
      dim_ok   = !val_zero && (32'(eff_val) <= 32'(MAX_DIM));
      rem_dec  = remaining_ff - REM_W'(remaining_ff != '0);
      val_x10  = {eff_val, 3'b000} + {2'b00, eff_val, 1'b0} + (VAL_W+4)'(digit);
   end

   // Next phase.
   always_comb begin
      phase_in = eff_phase;
      if (!active) begin
         phase_in = nps_pkg::PH_IDLE;
      end else if (binary_data) begin
         if (eof || rem_dec == '0) begin
            phase_in = nps_pkg::PH_IDLE;
         end
      end else if (token_end) begin
         case (eff_phase)
            nps_pkg::PH_MAGIC: begin
               phase_in = (eff_magic == nps_pkg::MAGIC_OK && !eof) ?
                          nps_pkg::PH_WIDTH : nps_pkg::PH_IDLE;
            end
            nps_pkg::PH_WIDTH: begin
               phase_in = (dim_ok && !eof) ? nps_pkg::PH_HEIGHT : nps_pkg::PH_IDLE;
            end
            nps_pkg::PH_HEIGHT: begin
               phase_in = (dim_ok && !eof) ? nps_pkg::PH_MAXVAL : nps_pkg::PH_IDLE;
            end
            nps_pkg::PH_MAXVAL: begin
               phase_in = val_zero ? nps_pkg::PH_IDLE : nps_pkg::PH_DATA;
            end
            default: begin
               phase_in = (eof || rem_dec == '0) ? nps_pkg::PH_IDLE : nps_pkg::PH_DATA;
            end
         endcase
      end else if (long_token) begin
         phase_in = nps_pkg::PH_IDLE;
      end
   end

   // Datapath updates and the result.
   always_comb begin
      file_type_in    = eff_type;
      tok_len_in      = eff_len;
      tok_val_in      = eff_val;
      digits_ended_in = eff_ended;
      magic_in        = eff_magic;
      width_in        = item.start_of_file ? '0 : width_ff;
      height_in       = item.start_of_file ? '0 : height_ff;
      maxval_in       = item.start_of_file ? '0 : maxval_ff;
      remaining_in    = item.start_of_file ? '0 : remaining_ff;
      area_in         = area_ff;
      result          = '0;

      if (!active) begin
         result = '0;
      end else if (binary_data) begin
         if (!eof) begin
            remaining_in     = rem_dec;
            result.valid     = 1'b1;
            result.data.kind = nps_pkg::KIND_PIXEL;
            result.data.pixel = c;
            result.data.last = (rem_dec == '0);
            result.data.image_width  = nps_pkg::DIM_OUT_W'(width_ff);
            result.data.image_height = nps_pkg::DIM_OUT_W'(height_ff);
            result.data.max_value    = maxval_ff;
            result.data.is_colour    = colour_type;
            result.data.ascii_mode   = ascii_type;
         end
      end else if (token_end) begin
         tok_len_in      = '0;
         tok_val_in      = '0;
         digits_ended_in = 1'b0;
         result.valid    = 1'b1;
         result.data.kind = nps_pkg::KIND_ERROR;
         case (eff_phase)
            nps_pkg::PH_MAGIC: begin
               if (eff_magic == nps_pkg::MAGIC_NONE) begin
                  result.data.error_code = nps_pkg::ERR_NO_P;
               end else if (eff_magic == nps_pkg::MAGIC_P) begin
                  result.data.error_code = nps_pkg::ERR_BAD_DIGIT;
               end else if (eff_magic == nps_pkg::MAGIC_BAD_TYPE) begin
                  result.data.error_code = nps_pkg::ERR_BAD_TYPE;
               end else begin
                  // A file that ends right after the magic misses its width.
                  result.valid = eof;
                  result.data.error_code = nps_pkg::ERR_WIDTH;
               end
            end
            nps_pkg::PH_WIDTH: begin
               if (!dim_ok) begin
                  result.data.error_code = nps_pkg::ERR_WIDTH;
               end else begin
                  width_in = DIM_W'(eff_val);
                  result.valid = eof;
                  result.data.error_code = nps_pkg::ERR_HEIGHT;
               end
            end
            nps_pkg::PH_HEIGHT: begin
               if (!dim_ok) begin
                  result.data.error_code = nps_pkg::ERR_HEIGHT;
               end else begin
                  height_in = DIM_W'(eff_val);
                  area_in   = AREA_W'(width_ff) * AREA_W'(DIM_W'(eff_val));
                  result.valid = eof;
                  result.data.error_code = nps_pkg::ERR_MAXVAL;
               end
            end
            nps_pkg::PH_MAXVAL: begin
               if (val_zero) begin
                  result.data.error_code = nps_pkg::ERR_MAXVAL;
               end else begin
                  maxval_in    = eff_val;
                  remaining_in = colour_type ? (REM_W'({area_ff, 1'b0}) + REM_W'(area_ff))
                                             : REM_W'(area_ff);
                  result.data.kind = nps_pkg::KIND_HEADER;
               end
            end
            default: begin
               if (eof && !(remaining_ff == REM_W'(1) && eff_len != '0)) begin
                  result.data.error_code = nps_pkg::ERR_SHORT_DATA;
               end else begin
                  remaining_in      = rem_dec;
                  result.data.kind  = nps_pkg::KIND_PIXEL;
                  result.data.pixel = eff_val[7:0];
                  result.data.last  = (rem_dec == '0);
               end
            end
         endcase
         if (result.data.kind != nps_pkg::KIND_ERROR) begin
            result.data.image_width  = nps_pkg::DIM_OUT_W'(width_ff);
            result.data.image_height = nps_pkg::DIM_OUT_W'(height_ff);
            result.data.max_value    = maxval_in;
            result.data.is_colour    = colour_type;
            result.data.ascii_mode   = ascii_type;
         end
      end else if (long_token) begin
         result.valid           = 1'b1;
         result.data.kind       = nps_pkg::KIND_ERROR;
         result.data.error_code = nps_pkg::ERR_LONG_TOKEN;
      end else begin
         tok_len_in = eff_len + LEN_W'(1);
         if (eff_phase == nps_pkg::PH_MAGIC) begin
            if (eff_len == '0) begin
               magic_in = (c == nps_pkg::CH_P) ? nps_pkg::MAGIC_P : nps_pkg::MAGIC_NONE;
            end else if (eff_len == LEN_W'(1) && eff_magic == nps_pkg::MAGIC_P && is_digit)
            begin
               if (good_type) begin
                  magic_in     = nps_pkg::MAGIC_OK;
                  file_type_in = 3'(digit);
               end else begin
                  magic_in = nps_pkg::MAGIC_BAD_TYPE;
               end
            end
         end else if (!eff_ended && is_digit) begin
            if (eff_phase == nps_pkg::PH_DATA) begin
               tok_val_in = val_x10[VAL_W-1:0];
            end else if (val_x10[VAL_W+3:VAL_W] != '0) begin
               tok_val_in = '1;
            end else begin
               tok_val_in = val_x10[VAL_W-1:0];
            end
         end else begin
            digits_ended_in = 1'b1;
         end
      end

      // Results only leave when the caller advances.
      result.valid = result.valid && step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= nps_pkg::PH_MAGIC;
         file_type_ff    <= '0;
         tok_len_ff      <= '0;
         tok_val_ff      <= '0;
         digits_ended_ff <= 1'b0;
         magic_ff        <= nps_pkg::MAGIC_NONE;
         width_ff        <= '0;
         height_ff       <= '0;
         maxval_ff       <= '0;
         remaining_ff    <= '0;
         area_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         file_type_ff    <= file_type_in;
         tok_len_ff      <= tok_len_in;
         tok_val_ff      <= tok_val_in;
         digits_ended_ff <= digits_ended_in;
         magic_ff        <= magic_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         maxval_ff       <= maxval_in;
         remaining_ff    <= remaining_in;
         area_ff         <= area_in;
      end
   end

   a_error_goes_idle: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.kind == nps_pkg::KIND_ERROR |=>
         phase_ff == nps_pkg::PH_IDLE)
      else $error("parser did not stop after an error result");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.last |=> phase_ff == nps_pkg::PH_IDLE)
      else $error("parser did not stop after the final sample");

   a_header_starts_data: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.kind == nps_pkg::KIND_HEADER |=>
         phase_ff == nps_pkg::PH_DATA && remaining_ff != '0)
      else $error("header result without a sample count");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == nps_pkg::PH_DATA |-> remaining_ff != '0)
      else $error("data phase with no samples left");

   a_token_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(tok_len_ff) <= 32'(MAX_TOKEN))
      else $error("token length above its limit");

endmodule

`default_nettype wire

[sv/netpbm_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// netpbm_stream_parser_core
// Byte-serial netpbm (P2, P3, P5, P6) reader: one file byte per request, one
// header, sample or error response at most per request.
// A request is held in the request register; its response is registered in the
// response register once that register is free or being emptied.
// Throughput: one request per cycle while the response side accepts, set by
// the single-pass parser update between the request and response registers.
// Reset (synchronous, active high) empties both registers and puts the parser
// in the magic-token phase, ready for a file without a start marker.
// ----------------------------------------------------------------------------
`default_nettype none

module netpbm_stream_parser_core #(
   parameter int MAX_TOKEN = nps_pkg::DEF_MAX_TOKEN,
   parameter int MAX_DIM   = nps_pkg::DEF_MAX_DIM
) (
   input wire logic     clock,
   input wire logic     reset,
   nps_stream_if.sink   req_chan,
   nps_stream_if.source rsp_chan
);

   logic                in_valid_ff, in_valid_in;
   nps_pkg::req_type    in_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   nps_pkg::rsp_type    rsp_data_ff;
   logic                step;
   logic                req_take;
   nps_pkg::result_type result;

   // The held request is processed whenever the response register can take
   // its result, so a new request can enter in the same cycle.
   assign step     = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || step;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   nps_parser #(
      .MAX_TOKEN (MAX_TOKEN),
      .MAX_DIM   (MAX_DIM)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = result.valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_chan.payload;
      end
      if (step) begin
         rsp_data_ff <= result.data;
      end
   end

endmodule

`default_nettype wire

[tb/tb_netpbm_stream_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_netpbm_stream_parser_core
// Self-checking bench for the byte-serial netpbm reader. A queue of file
// bytes, made of directed headers and random PGM/PPM images (clean, cut
// short, corrupted or plain noise), feeds a valid/ready driver. Every accepted
// request runs through a local parser model. A monitor checks each response
// against the oldest predicted one. Both sides stall at random.
// ----------------------------------------------------------------------------

module tb_netpbm_stream_parser_core;

   localparam int TOKEN_LIMIT  = nps_pkg::DEF_MAX_TOKEN;
   localparam int DIM_LIMIT    = nps_pkg::DEF_MAX_DIM;
   localparam int RANDOM_ITEMS = 525;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nps_stream_if #(.payload_type(nps_pkg::req_type)) req_if ();
   nps_stream_if #(.payload_type(nps_pkg::rsp_type)) rsp_if ();

   netpbm_stream_parser_core #(
      .MAX_TOKEN(TOKEN_LIMIT),
      .MAX_DIM  (DIM_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Parser model state.
   nps_pkg::phase_type parse_phase;
   logic [2:0]  file_kind;
   logic [1:0]  magic_state;
   int unsigned token_len;
   int unsigned token_val;
   bit          digits_done;
   int unsigned width_val;
   int unsigned height_val;
   int unsigned maxval_val;
   int unsigned samples_left;

   nps_pkg::req_type pending_req[$];
   nps_pkg::rsp_type expected_rsp[$];
   nps_pkg::rsp_type expected_now;
   bit      next_sof;
   int      total_items;
   int      accepted_count = 0;
   int      fail_count = 0;
   int      cycle_count = 0;

   // Neither side stalls during this window.
   wire quiet_span = (cycle_count >= 400) && (cycle_count < 900);

   function automatic bit colour_file();
      return file_kind == nps_pkg::PNM_ASCII_RGB || file_kind == nps_pkg::PNM_BINARY_RGB;
   endfunction

   function automatic bit ascii_file();
      return file_kind == nps_pkg::PNM_ASCII_GRAY || file_kind == nps_pkg::PNM_ASCII_RGB;
   endfunction

   task automatic clear_token();
      token_len   = 0;
      token_val   = 0;
      digits_done = 1'b0;
   endtask

   task automatic restart_file();
      parse_phase  = nps_pkg::PH_MAGIC;
      file_kind    = '0;
      magic_state  = nps_pkg::MAGIC_NONE;
      width_val    = 0;
      height_val   = 0;
      maxval_val   = 0;
      samples_left = 0;
      clear_token();
   endtask

   task automatic push_result(logic [1:0] kind, logic [7:0] pix, bit lst);
      nps_pkg::rsp_type o;
      o              = '0;
      o.kind         = kind;
      o.pixel        = pix;
      o.image_width  = width_val[nps_pkg::DIM_OUT_W-1:0];
      o.image_height = height_val[nps_pkg::DIM_OUT_W-1:0];
      o.max_value    = maxval_val[nps_pkg::VAL_W-1:0];
      o.is_colour    = colour_file();
      o.ascii_mode   = ascii_file();
      o.last         = lst;
      expected_rsp.push_back(o);
   endtask

   task automatic push_error(logic [2:0] code);
      nps_pkg::rsp_type o;
      o            = '0;
      o.kind       = nps_pkg::KIND_ERROR;
      o.error_code = code;
      expected_rsp.push_back(o);
      parse_phase = nps_pkg::PH_IDLE;
   endtask

   task automatic take_sample(int unsigned v);
      if (samples_left > 0) samples_left--;
      if (samples_left == 0) parse_phase = nps_pkg::PH_IDLE;
      clear_token();
      push_result(nps_pkg::KIND_PIXEL, v[7:0], samples_left == 0);
   endtask

   task automatic close_token(bit at_eof);
      int unsigned v;
      v = token_val;
      case (parse_phase)
         nps_pkg::PH_MAGIC: begin
            if (magic_state == nps_pkg::MAGIC_NONE) push_error(nps_pkg::ERR_NO_P);
            else if (magic_state == nps_pkg::MAGIC_P) push_error(nps_pkg::ERR_BAD_DIGIT);
            else if (magic_state == nps_pkg::MAGIC_BAD_TYPE) push_error(nps_pkg::ERR_BAD_TYPE);
            else begin
               parse_phase = nps_pkg::PH_WIDTH;
               clear_token();
               if (at_eof) push_error(nps_pkg::ERR_WIDTH);
            end
         end
         nps_pkg::PH_WIDTH: begin
            if (v < 1 || v > DIM_LIMIT) push_error(nps_pkg::ERR_WIDTH);
            else begin
               width_val   = v;
               parse_phase = nps_pkg::PH_HEIGHT;
               clear_token();
               if (at_eof) push_error(nps_pkg::ERR_HEIGHT);
            end
         end
         nps_pkg::PH_HEIGHT: begin
            if (v < 1 || v > DIM_LIMIT) push_error(nps_pkg::ERR_HEIGHT);
            else begin
               height_val  = v;
               parse_phase = nps_pkg::PH_MAXVAL;
               clear_token();
               if (at_eof) push_error(nps_pkg::ERR_MAXVAL);
            end
         end
         nps_pkg::PH_MAXVAL: begin
            if (v < 1) push_error(nps_pkg::ERR_MAXVAL);
            else begin
               maxval_val   = v;
               samples_left = width_val * height_val * (colour_file() ? 3 : 1);
               parse_phase  = nps_pkg::PH_DATA;
               clear_token();
               push_result(nps_pkg::KIND_HEADER, 8'd0, 1'b0);
            end
         end
         default: begin
            // At end of file only a non-empty final sample survives.
            if (at_eof && !(samples_left == 1 && token_len > 0))
               push_error(nps_pkg::ERR_SHORT_DATA);
            else take_sample(v);
         end
      endcase
   endtask

   task automatic parse_request(nps_pkg::req_type r);
      logic [7:0]  c;
      int unsigned d;
      c = r.byte_req;
      if (r.start_of_file) restart_file();
      if (parse_phase == nps_pkg::PH_IDLE) return;

      if (parse_phase == nps_pkg::PH_DATA && !ascii_file()) begin
         if (r.end_of_file) begin
            parse_phase = nps_pkg::PH_IDLE;
            return;
         end
         if (samples_left > 0) samples_left--;
         if (samples_left == 0) parse_phase = nps_pkg::PH_IDLE;
         push_result(nps_pkg::KIND_PIXEL, c, samples_left == 0);
         return;
      end

      if (r.end_of_file) begin
         close_token(1'b1);
         return;
      end
      if (c == nps_pkg::CH_SPACE || c == nps_pkg::CH_NEWLINE) begin
         close_token(1'b0);
         return;
      end
      if (token_len >= TOKEN_LIMIT) begin
         push_error(nps_pkg::ERR_LONG_TOKEN);
         return;
      end

      if (parse_phase == nps_pkg::PH_MAGIC) begin
         if (token_len == 0) begin
            magic_state = (c == nps_pkg::CH_P) ? nps_pkg::MAGIC_P : nps_pkg::MAGIC_NONE;
         end else if (token_len == 1 && magic_state == nps_pkg::MAGIC_P &&
                      c >= nps_pkg::CH_ZERO && c <= nps_pkg::CH_NINE) begin
            d = c - nps_pkg::CH_ZERO;
            if (d == nps_pkg::PNM_ASCII_GRAY || d == nps_pkg::PNM_ASCII_RGB ||
                d == nps_pkg::PNM_BINARY_GRAY || d == nps_pkg::PNM_BINARY_RGB) begin
               magic_state = nps_pkg::MAGIC_OK;
               file_kind   = d[2:0];
            end else begin
               magic_state = nps_pkg::MAGIC_BAD_TYPE;
            end
         end
      end else if (!digits_done && c >= nps_pkg::CH_ZERO && c <= nps_pkg::CH_NINE) begin
         d = c - nps_pkg::CH_ZERO;
         // Samples wrap at 16 bits; header values saturate.
         if (parse_phase == nps_pkg::PH_DATA) token_val = (token_val * 10 + d) & 32'hFFFF;
         else if (token_val > (65535 - d) / 10) token_val = 65535;
         else token_val = token_val * 10 + d;
      end else begin
         digits_done = 1'b1;
      end
      token_len++;
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(logic [7:0] c);
      nps_pkg::req_type r;
      r.byte_req      = c;
      r.start_of_file = next_sof;
      r.end_of_file   = 1'b0;
      pending_req.push_back(r);
      next_sof = 1'b0;
   endtask

   task automatic add_eof();
      nps_pkg::req_type r;
      r.byte_req      = $urandom_range(255);
      r.start_of_file = next_sof;
      r.end_of_file   = 1'b1;
      pending_req.push_back(r);
      next_sof = 1'b0;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic directed_file(string s, bit with_eof);
      next_sof = 1'b1;
      add_text(s);
      if (with_eof) add_eof();
   endtask

   function automatic logic [7:0] pick_sep();
      return $urandom_range(1) ? nps_pkg::CH_SPACE : nps_pkg::CH_NEWLINE;
   endfunction

   // Decimal text with an occasional leading zero or a trailing non-digit.
   function automatic string number_text(int unsigned v);
      string s;
      string junk_chars;
      junk_chars = "#a/:Z";
      s = $sformatf("%0d", v);
      if ($urandom_range(9) < 2) s = {"0", s};
      if ($urandom_range(9) < 2) s = {s, junk_chars.substr(0, 0)};
      if ($urandom_range(9) < 1) s = {s, junk_chars.substr($urandom_range(4), 0)};
      return s;
   endfunction

   task automatic random_image(bit broken);
      logic [2:0]  t;
      int unsigned w, h, mv, n, v;
      int          s0, len, idx, cut;
      nps_pkg::req_type r;

      case ($urandom_range(3))
         0: t = nps_pkg::PNM_ASCII_GRAY;
         1: t = nps_pkg::PNM_ASCII_RGB;
         2: t = nps_pkg::PNM_BINARY_GRAY;
         default: t = nps_pkg::PNM_BINARY_RGB;
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      h = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      case ($urandom_range(4))
         0: mv = 1;
         1: mv = 255;
         2: mv = 65535;
         3: mv = $urandom_range(1, 65535);
         default: mv = $urandom_range(65536, 9999999);
      endcase
      n = w * h * ((t == nps_pkg::PNM_ASCII_RGB || t == nps_pkg::PNM_BINARY_RGB) ? 3 : 1);

      next_sof = ($urandom_range(19) != 0);
      s0 = pending_req.size();
      add_byte(nps_pkg::CH_P);
      add_byte(nps_pkg::CH_ZERO + t);
      if ($urandom_range(9) == 0) add_text("x");
      add_byte(pick_sep());
      add_text(number_text(w));
      add_byte(pick_sep());
      add_text(number_text(h));
      add_byte(pick_sep());
      add_text(number_text(mv));
      add_byte(pick_sep());

      if (t == nps_pkg::PNM_ASCII_GRAY || t == nps_pkg::PNM_ASCII_RGB) begin
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
               0, 1: v = $urandom_range(65535);
               2: v = $urandom_range(999999);
               default: v = $urandom_range(255);
            endcase
            add_text(number_text(v));
            if (i == n - 1 && $urandom_range(2) == 0) add_eof();
            else add_byte(pick_sep());
            // A doubled separator makes an empty, zero-valued sample.
            if (i < n - 1 && $urandom_range(19) == 0) add_byte(pick_sep());
         end
      end else begin
         for (int i = 0; i < n; i++) add_byte($urandom_range(255));
      end

      if (broken) begin
         len = pending_req.size() - s0;
         idx = s0 + $urandom_range(len - 1);
         case ($urandom_range(2))
            0: begin
               cut = $urandom_range(1, len - 1);
               while (pending_req.size() > s0 + cut) void'(pending_req.pop_back());
               if ($urandom_range(1)) add_eof();
            end
            1: begin
               r = pending_req[idx];
               r.byte_req = $urandom_range(255);
               pending_req[idx] = r;
            end
            default: begin
               idx = s0 + $urandom_range((len < 12 ? len : 12) - 1);
               r = pending_req[idx];
               r.byte_req = pick_sep();
               pending_req[idx] = r;
            end
         endcase
      end

      // Anything after a finished image is ignored until the next start.
      if ($urandom_range(9) < 3) add_eof();
      if ($urandom_range(9) == 0) add_text("7 ");
   endtask

   task automatic build_stimulus();
      int base;
      // First file comes straight after reset with no start marker.
      next_sof = 1'b0;
      add_text("P5 1 1 1\n");
      add_byte(8'hFF);
      directed_file("x\n", 1'b0);
      directed_file("", 1'b1);
      directed_file("P\n", 1'b0);
      directed_file("Pq ", 1'b0);
      directed_file("P7 ", 1'b0);
      directed_file("P2junk 1 1 1 300", 1'b1);
      directed_file("P6 0 ", 1'b0);
      directed_file("P6 4097 ", 1'b0);
      directed_file("P3 2 4097 ", 1'b0);
      directed_file("P5 4096 1 65535\n", 1'b1);
      directed_file("P5 1 4096 99999 ", 1'b1);
      directed_file("P6 1 1 0 ", 1'b0);
      directed_file("P2", 1'b1);
      directed_file("P2 1", 1'b1);
      directed_file("P2 1 1", 1'b1);
      directed_file("P2 1 2 9 5", 1'b1);
      directed_file("P3 1 1 9 1 2  ", 1'b1);
      directed_file("P5 2 1 255 \n ", 1'b0);
      directed_file("P5 ", 1'b0);
      for (int i = 0; i <= TOKEN_LIMIT; i++) add_byte(nps_pkg::CH_ZERO);

      base = pending_req.size();
      while (pending_req.size() < base + RANDOM_ITEMS) begin
         if ($urandom_range(99) < 5) begin
            next_sof = 1'b1;
            repeat ($urandom_range(1, 10)) add_byte($urandom_range(255));
         end else begin
            random_image($urandom_range(99) < 25);
         end
      end
   endtask

   function automatic string rsp_text(nps_pkg::rsp_type r);
      return $sformatf({"kind %0d pixel %0d w %0d h %0d max %0d colour %0b ascii %0b",
                        " last %0b code %0d"},
                       r.kind, r.pixel, r.image_width, r.image_height, r.max_value,
                       r.is_colour, r.ascii_mode, r.last, r.error_code);
   endfunction

   // ------------------------------------------------------- driver and monitor

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            parse_request(req_if.payload);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_req.size() != 0 && (quiet_span || $urandom_range(99) >= 8)) begin
               req_if.payload <= pending_req.pop_front();
               req_if.valid   <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: %s", rsp_text(rsp_if.payload));
            end else begin
               expected_now = expected_rsp.pop_front();
               if (rsp_if.payload !== expected_now) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("response mismatch: expected %s", rsp_text(expected_now));
                     $display("                   actual   %s", rsp_text(rsp_if.payload));
                  end
               end
            end
         end
         rsp_if.ready <= quiet_span || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      restart_file();
      build_stimulus();
      total_items = pending_req.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || expected_rsp.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[netpbm_stream_parser_core.f]
sv/nps_pkg.sv
sv/nps_stream_if.sv
sv/nps_parser.sv
sv/netpbm_stream_parser_core.sv
tb/tb_netpbm_stream_parser_core.sv
